// ===== rtl/va_pkg.sv =====
package va_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int NUM_VOICES  = 16;

    localparam int SRC_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
    localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int FC_W    = $clog2(NUM_VOICES + 1);
    localparam int CMP_W   = 8;

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_REMOVE    = 2'd1,
        CMD_UPDATE    = 2'd2,
        CMD_REBALANCE = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_VOICE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ALWAYS_ON   = 2'd1;

    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_REVOKE = 1'b1;

    typedef struct packed {
        logic [7:0]         id;
        logic               playing;
        logic [7:0]         prio;
        logic [15:0]        gain;
        logic [VOICE_W-1:0] voice;
    } entry_t;

    typedef struct packed {
        logic [7:0]         src;
        logic [VOICE_W-1:0] voice;
        logic               action;
        logic               ovf;
    } event_t;

    // Requests from the sequencer to the free-voice stack.
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [VOICE_W-1:0] voice;
    } stk_ctl_t;

    // What the free-voice stack reports back.
    typedef struct packed {
        logic [VOICE_W-1:0] top;
        logic [FC_W-1:0]    free_count;
        logic [FC_W-1:0]    held_count;
    } stk_stat_t;

    function automatic logic [3:0] voice_out(input logic [VOICE_W-1:0] v);
        logic [VOICE_W+3:0] t;
        t = {4'b0000, v};
        return t[3:0];
    endfunction

endpackage

// ===== rtl/voice_allocator_top.sv =====
// Voice allocator. Keeps a table of up to MAX_SOURCES sound sources and a
// stack of NUM_VOICES free voices, and reports every voice change as one
// result transaction (source, voice, assign or revoke, always-on overflow,
// and a last flag on the final result of a command). Commands are add,
// remove, update and rebalance; one command is worked on at a time and
// s_ready is high only while the block is idle. The table sits in a small
// two-read, one-write memory walked by a sequencer around one 25-bit key
// comparator. Add writes one new entry; update and remove search the table
// entry by entry, and removal then shifts the later entries down one place;
// rebalance runs a bubble sort over the table, then a revoke walk and an
// assign walk. Results wait in a pending register and an output register
// and stall the sequencer only when both are full.
// Configuration writes are always accepted and must be issued while idle.
module voice_allocator_top
    import va_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_source_id,
    input  logic        s_playing,
    input  logic [7:0]  s_priority_req,
    input  logic [15:0] s_gain,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_event_source,
    output logic [3:0]  m_event_voice,
    output logic        m_action,
    output logic        m_always_on_overflow,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_ADD      = 14'b00000000000010,
        ST_FIND_RD  = 14'b00000000000100,
        ST_FIND_CHK = 14'b00000000001000,
        ST_SHIFT_RD = 14'b00000000010000,
        ST_SHIFT_WR = 14'b00000000100000,
        ST_SORT_RD  = 14'b00000001000000,
        ST_SORT_CMP = 14'b00000010000000,
        ST_SORT_WR2 = 14'b00000100000000,
        ST_REV_RD   = 14'b00001000000000,
        ST_REV_EMIT = 14'b00010000000000,
        ST_ASG_RD   = 14'b00100000000000,
        ST_ASG_EMIT = 14'b01000000000000,
        ST_DONE     = 14'b10000000000000
    } state_t;

    // Configuration registers.
    logic [4:0] voice_limit_reg;
    logic [7:0] always_on_reg;

    // Sequencer state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             swapped_reg, swapped_next;
    logic [MAX_SOURCES-1:0] has_reg, has_next;

    // The accepted command transaction.
    cmd_t        cmd_reg;
    logic [7:0]  id_reg;
    logic        play_reg;
    logic [7:0]  prio_reg;
    logic [15:0] gain_reg;

    // Source table memory.
    entry_t           mem [MAX_SOURCES];
    logic             we;
    logic [SRC_W-1:0] waddr;
    entry_t           wdata;
    logic             rd_en;
    logic [SRC_W-1:0] raddr_a, raddr_b;
    entry_t           rd_a, rd_b;

    // Result path: one pending event, so that the last flag is known when the
    // event moves on to the output register.
    event_t pend_reg, pend_next;
    logic   pend_valid_reg, pend_valid_next;
    event_t out_reg, out_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_last_reg, out_last_next;

    logic   emit_req;
    event_t emit_ev;
    logic   out_free;
    logic   can_emit;

    stk_ctl_t  stk_ctl;
    stk_stat_t stk_stat;

    logic [CNT_W-1:0] idx_inc;
    logic [24:0]      key_a, key_b;
    logic             start_rev, start_asg, sort_adv;

    va_free_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .stat    (stk_stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid              = out_valid_reg;
    assign m_event_source       = out_reg.src;
    assign m_event_voice        = voice_out(out_reg.voice);
    assign m_action             = out_reg.action;
    assign m_always_on_overflow = out_reg.ovf;
    assign m_last               = out_last_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;
    assign idx_inc  = idx_reg + CNT_W'(1);

    // Sort key: playing, then priority, then gain, all descending.
    assign key_a = {rd_a.playing, rd_a.prio, rd_a.gain};
    assign key_b = {rd_b.playing, rd_b.prio, rd_b.gain};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_limit_reg <= 5'd16;
            always_on_reg   <= 8'd255;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VOICE_LIMIT: voice_limit_reg <= cfg_data[4:0];
                CFG_ALWAYS_ON:   always_on_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_a <= mem[raddr_a];
            rd_b <= mem[raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= cmd_t'(s_cmd);
            id_reg   <= s_source_id;
            play_reg <= s_playing;
            prio_reg <= s_priority_req;
            gain_reg <= s_gain;
        end
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        pass_reg     <= pass_next;
        idx_reg      <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            has_reg        <= '0;
            swapped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            has_reg        <= has_next;
            swapped_reg    <= swapped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        swapped_next = swapped_reg;
        has_next     = has_reg;
        we           = 1'b0;
        waddr        = idx_reg[SRC_W-1:0];
        wdata        = rd_a;
        rd_en        = 1'b0;
        raddr_a      = idx_reg[SRC_W-1:0];
        raddr_b      = idx_inc[SRC_W-1:0];
        emit_req     = 1'b0;
        emit_ev      = '0;
        stk_ctl      = '0;
        start_rev    = 1'b0;
        start_asg    = 1'b0;
        sort_adv     = 1'b0;

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next = '0;
                    case (cmd_t'(s_cmd))
                        CMD_ADD:    state_next = ST_ADD;
                        CMD_REMOVE: state_next = ST_FIND_RD;
                        CMD_UPDATE: state_next = ST_FIND_RD;
                        default: begin
                            pass_next    = count_reg - CNT_W'(1);
                            swapped_next = 1'b0;
                            if (count_reg < CNT_W'(2)) begin
                                start_rev = 1'b1;
                            end else begin
                                state_next = ST_SORT_RD;
                            end
                        end
                    endcase
                end
            end

            ST_ADD: begin
                if (count_reg < CNT_W'(MAX_SOURCES)) begin
                    we          = 1'b1;
                    waddr       = count_reg[SRC_W-1:0];
                    wdata.id      = id_reg;
                    wdata.playing = play_reg;
                    wdata.prio    = prio_reg;
                    wdata.gain    = gain_reg;
                    wdata.voice   = '0;
                    has_next[count_reg[SRC_W-1:0]] = 1'b0;
                    if (stk_stat.free_count != '0 &&
                        CMP_W'(stk_stat.held_count) < CMP_W'(voice_limit_reg)) begin
                        wdata.voice = stk_stat.top;
                        has_next[count_reg[SRC_W-1:0]] = 1'b1;
                        stk_ctl.pop = 1'b1;
                        emit_req    = 1'b1;
                        emit_ev     = '{src: id_reg, voice: stk_stat.top,
                                        action: ACT_ASSIGN, ovf: 1'b0};
                    end
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_DONE;
            end

            ST_FIND_RD: begin
                if (idx_reg >= count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_FIND_CHK;
                end
            end

            ST_FIND_CHK: begin
                if (rd_a.id != id_reg) begin
                    idx_next   = idx_inc;
                    state_next = ST_FIND_RD;
                end else if (cmd_reg == CMD_UPDATE) begin
                    we            = 1'b1;
                    wdata.playing = play_reg;
                    wdata.prio    = prio_reg;
                    wdata.gain    = gain_reg;
                    state_next    = ST_DONE;
                end else begin
                    if (has_reg[idx_reg[SRC_W-1:0]]) begin
                        stk_ctl.push  = 1'b1;
                        stk_ctl.voice = rd_a.voice;
                        emit_req      = 1'b1;
                        emit_ev       = '{src: id_reg, voice: rd_a.voice,
                                          action: ACT_REVOKE, ovf: 1'b0};
                    end
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_SHIFT_RD;
                end
            end

            ST_SHIFT_RD: begin
                if (idx_reg < count_reg) begin
                    rd_en      = 1'b1;
                    raddr_a    = idx_inc[SRC_W-1:0];
                    state_next = ST_SHIFT_WR;
                end else begin
                    has_next[idx_reg[SRC_W-1:0]] = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT_WR: begin
                we = 1'b1;
                has_next[idx_reg[SRC_W-1:0]] = has_reg[idx_inc[SRC_W-1:0]];
                idx_next   = idx_inc;
                state_next = ST_SHIFT_RD;
            end

            ST_SORT_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SORT_CMP;
            end

            ST_SORT_CMP: begin
                if (key_a < key_b) begin
                    we    = 1'b1;
                    wdata = rd_b;
                    has_next[idx_reg[SRC_W-1:0]] = has_reg[idx_inc[SRC_W-1:0]];
                    has_next[idx_inc[SRC_W-1:0]] = has_reg[idx_reg[SRC_W-1:0]];
                    swapped_next = 1'b1;
                    state_next   = ST_SORT_WR2;
                end else begin
                    sort_adv = 1'b1;
                end
            end

            ST_SORT_WR2: begin
                we       = 1'b1;
                waddr    = idx_inc[SRC_W-1:0];
                wdata    = rd_a;
                sort_adv = 1'b1;
            end

            ST_REV_RD: begin
                if (idx_reg >= count_reg) begin
                    start_asg = 1'b1;
                end else if (!has_reg[idx_reg[SRC_W-1:0]]) begin
                    idx_next = idx_inc;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_REV_EMIT;
                end
            end

            ST_REV_EMIT: begin
                if (can_emit) begin
                    stk_ctl.push  = 1'b1;
                    stk_ctl.voice = rd_a.voice;
                    has_next[idx_reg[SRC_W-1:0]] = 1'b0;
                    emit_req = 1'b1;
                    emit_ev  = '{src: rd_a.id, voice: rd_a.voice, action: ACT_REVOKE,
                                 ovf: rd_a.playing && (rd_a.prio == always_on_reg)};
                    idx_next   = idx_inc;
                    state_next = ST_REV_RD;
                end
            end

            ST_ASG_RD: begin
                if (idx_reg >= count_reg ||
                    CMP_W'(idx_reg) >= CMP_W'(voice_limit_reg) ||
                    stk_stat.free_count == '0) begin
                    state_next = ST_DONE;
                end else if (has_reg[idx_reg[SRC_W-1:0]]) begin
                    idx_next = idx_inc;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_ASG_EMIT;
                end
            end

            ST_ASG_EMIT: begin
                if (!rd_a.playing) begin
                    idx_next   = idx_inc;
                    state_next = ST_ASG_RD;
                end else if (can_emit) begin
                    stk_ctl.pop = 1'b1;
                    we          = 1'b1;
                    wdata.voice = stk_stat.top;
                    has_next[idx_reg[SRC_W-1:0]] = 1'b1;
                    emit_req = 1'b1;
                    emit_ev  = '{src: rd_a.id, voice: stk_stat.top,
                                 action: ACT_ASSIGN, ovf: 1'b0};
                    idx_next   = idx_inc;
                    state_next = ST_ASG_RD;
                end
            end

            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // End of one compare of a bubble-sort pass.
        if (sort_adv) begin
            if (idx_inc < pass_reg) begin
                idx_next   = idx_inc;
                state_next = ST_SORT_RD;
            end else begin
                pass_next = pass_reg - CNT_W'(1);
                if (swapped_next && pass_reg > CNT_W'(1)) begin
                    idx_next     = '0;
                    swapped_next = 1'b0;
                    state_next   = ST_SORT_RD;
                end else begin
                    start_rev = 1'b1;
                end
            end
        end

        // Revoke walk covers ranks from voice_limit to the end of the table.
        if (start_rev) begin
            if (CMP_W'(voice_limit_reg) >= CMP_W'(count_reg)) begin
                start_asg = 1'b1;
            end else begin
                idx_next   = CNT_W'(voice_limit_reg);
                state_next = ST_REV_RD;
            end
        end

        if (start_asg) begin
            idx_next   = '0;
            state_next = ST_ASG_RD;
        end

        // A new event pushes the pending one out as a non-final result.
        if (emit_req) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_ev;
            pend_valid_next = 1'b1;
        end
    end

endmodule

// ===== rtl/va_free_stack.sv =====
module va_free_stack
    import va_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  stk_ctl_t  ctl,
    output stk_stat_t stat
);

    logic [VOICE_W-1:0] stack_reg [NUM_VOICES];
    logic [FC_W-1:0]    free_reg;
    logic [FC_W-1:0]    held_reg;
    logic [FC_W-1:0]    top_idx;

    assign top_idx         = free_reg - FC_W'(1);
    assign stat.top        = stack_reg[top_idx[VOICE_W-1:0]];
    assign stat.free_count = free_reg;
    assign stat.held_count = held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                stack_reg[i] <= VOICE_W'(i);
            end
            free_reg <= FC_W'(NUM_VOICES);
            held_reg <= '0;
        end else if (ctl.pop) begin
            free_reg <= free_reg - FC_W'(1);
            held_reg <= held_reg + FC_W'(1);
        end else if (ctl.push) begin
            // A voice that would overflow the stack is dropped.
            if (free_reg < FC_W'(NUM_VOICES)) begin
                stack_reg[free_reg[VOICE_W-1:0]] <= ctl.voice;
                free_reg <= free_reg + FC_W'(1);
            end
            if (held_reg != '0) begin
                held_reg <= held_reg - FC_W'(1);
            end
        end
    end

endmodule

// ===== rtl/va_checker.sv =====
module va_checker
    import va_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_event_source,
    input logic [3:0]  m_event_voice,
    input logic        m_action,
    input logic        m_always_on_overflow,
    input logic        m_last
);

    // A stalled result transaction holds its source, voice, action and last flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_source) &&
            $stable(m_event_voice) && $stable(m_action) && $stable(m_last))
        else $error("stalled result changed");

    // One command at a time: no new command right after one is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted while busy");

    // Only revokes can carry the always-on overflow flag.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_ASSIGN) |-> !m_always_on_overflow)
        else $error("overflow flag on an assignment");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind voice_allocator_top va_checker u_va_checker (.*);
